// File: hw/rtl/mmhg_pkg.sv
// Package of the min/max height grid: widths, register indexes, controller
// states and the command/status structs between controller and datapath.
// Depends on nothing; the interfaces, controller, datapath and top import it.
package mmhg_pkg;

    // Default side of the square grid, in cells.
    localparam int GRID_SIDE_DEF = 128;

    // Field widths fixed by the word formats.
    localparam int COORD_W   = 20;
    localparam int SCALE_W   = 16;
    localparam int LIMIT_W   = 19;
    localparam int CELL_IX_W = 7;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 20;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CELLS_PER_M  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPREAD_LIMIT = 2'd3;

    // Register reset values.
    localparam logic [SCALE_W-1:0] CELLS_PER_M_RST  = 16'd2560;
    localparam logic [LIMIT_W-1:0] SPREAD_LIMIT_RST = 19'd26;

    // Operation codes of an input word.
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_READ   = 1'b1;

    // Controller states.
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MUL,
        S_ADDR,
        S_RD,
        S_MOD,
        S_DELIVER
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // capture an accepted input word
        logic mul;       // register the scaled offsets
        logic addr;      // register cell address and in-grid flag
        logic rd;        // read the cell from both memories
        logic modify;    // update or clear the cell just read
        logic res_zero;  // result of a read that missed the grid
        logic deliver;   // move the result into the output register
        logic clr_wr;    // clearing pass: zero one flag entry
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic op_read;   // the word in work is a read
        logic hit;       // the cell lies inside the grid
        logic clr_last;  // clearing pass is at its last entry
        logic out_free;  // output register can take a result
    } t_sts;

endpackage

// File: hw/rtl/mmhg_req_if.sv
// Input channel of the min/max height grid: valid, ready and one input word.
// Depends on mmhg_pkg for the field widths.
interface mmhg_req_if;
    import mmhg_pkg::*;

    logic                        valid;
    logic                        ready;
    logic                        operation;
    logic signed [COORD_W-1:0]   point_x;
    logic signed [COORD_W-1:0]   point_y;
    logic signed [COORD_W-1:0]   point_z;
    logic                        point_obstacle;
    logic        [CELL_IX_W-1:0] cell_col;
    logic        [CELL_IX_W-1:0] cell_row;

    modport source (
        output valid, operation, point_x, point_y, point_z, point_obstacle,
               cell_col, cell_row,
        input  ready
    );

    modport sink (
        input  valid, operation, point_x, point_y, point_z, point_obstacle,
               cell_col, cell_row,
        output ready
    );
endinterface

// File: hw/rtl/mmhg_rsp_if.sv
// Output channel of the min/max height grid: valid, ready and one result word.
// Depends on mmhg_pkg for the field widths.
interface mmhg_rsp_if;
    import mmhg_pkg::*;

    logic                      valid;
    logic                      ready;
    logic                      cell_used;
    logic signed [COORD_W-1:0] top_height;
    logic                      cell_obstacle;

    modport source (
        output valid, cell_used, top_height, cell_obstacle,
        input  ready
    );

    modport sink (
        input  valid, cell_used, top_height, cell_obstacle,
        output ready
    );
endinterface

// File: hw/rtl/mmhg_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing; the datapath instantiates it for the cell stores.
module mmhg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// File: hw/rtl/mmhg_ctrl.sv
// Controller of the min/max height grid: the state machine that steps one
// word through scale, address, read and update. Depends on mmhg_pkg.
module mmhg_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  mmhg_pkg::t_sts i_sts,
    output mmhg_pkg::t_cmd o_cmd
);
    import mmhg_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register; reset starts the clearing pass.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (i_sts.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) n_state = S_MUL;
            end
            S_MUL: begin
                n_state = S_ADDR;
            end
            S_ADDR: begin
                n_state = S_RD;
            end
            S_RD: begin
                if (i_sts.hit) begin
                    n_state = S_MOD;
                end else if (i_sts.op_read) begin
                    n_state = S_DELIVER;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_MOD: begin
                n_state = i_sts.op_read ? S_DELIVER : S_IDLE;
            end
            S_DELIVER: begin
                if (i_sts.out_free) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Outputs: handshake and datapath commands.
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
            end
            S_ADDR: begin
                o_cmd.addr = 1'b1;
            end
            S_RD: begin
                o_cmd.rd       = i_sts.hit;
                o_cmd.res_zero = !i_sts.hit;
            end
            S_MOD: begin
                o_cmd.modify = 1'b1;
            end
            S_DELIVER: begin
                o_cmd.deliver = i_sts.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end
endmodule

// File: hw/rtl/mmhg_dp.sv
// Datapath of the min/max height grid: configuration registers, cell index
// arithmetic, the flag and height stores and the output register.
// Depends on mmhg_pkg and mmhg_ram.
module mmhg_dp #(
    parameter int GRID_SIDE = mmhg_pkg::GRID_SIDE_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Configuration write port.
    input  logic                                i_cfg_we,
    input  logic [mmhg_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [mmhg_pkg::CFG_DAT_W-1:0]      i_cfg_data,
    // Input word.
    input  logic                                i_operation,
    input  logic signed [mmhg_pkg::COORD_W-1:0] i_point_x,
    input  logic signed [mmhg_pkg::COORD_W-1:0] i_point_y,
    input  logic signed [mmhg_pkg::COORD_W-1:0] i_point_z,
    input  logic                                i_point_obstacle,
    input  logic [mmhg_pkg::CELL_IX_W-1:0]      i_cell_col,
    input  logic [mmhg_pkg::CELL_IX_W-1:0]      i_cell_row,
    // Result word.
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic                                o_cell_used,
    output logic signed [mmhg_pkg::COORD_W-1:0] o_top_height,
    output logic                                o_cell_obstacle,
    // Controller link.
    input  mmhg_pkg::t_cmd                      i_cmd,
    output mmhg_pkg::t_sts                      o_sts
);
    import mmhg_pkg::*;

    localparam int CELLS = GRID_SIDE * GRID_SIDE;
    localparam int AW    = $clog2(CELLS);
    localparam int IW    = $clog2(GRID_SIDE);
    localparam int DW    = COORD_W + 1;          // coordinate difference
    localparam int PW    = DW + SCALE_W + 1;     // scaled difference
    localparam int QW    = PW - 17;              // magnitude of the quotient
    localparam int HW    = 2 * COORD_W;          // low and high heights

    // Configuration registers.
    logic signed [COORD_W-1:0] r_origin_x;
    logic signed [COORD_W-1:0] r_origin_y;
    logic [SCALE_W-1:0]        r_cells_per_m;
    logic [LIMIT_W-1:0]        r_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x    <= '0;
            r_origin_y    <= '0;
            r_cells_per_m <= CELLS_PER_M_RST;
            r_limit       <= SPREAD_LIMIT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ORIGIN_X:     r_origin_x    <= $signed(i_cfg_data[COORD_W-1:0]);
                CFG_ORIGIN_Y:     r_origin_y    <= $signed(i_cfg_data[COORD_W-1:0]);
                CFG_CELLS_PER_M:  r_cells_per_m <= i_cfg_data[SCALE_W-1:0];
                CFG_SPREAD_LIMIT: r_limit       <= i_cfg_data[LIMIT_W-1:0];
                default:          r_limit       <= r_limit;
            endcase
        end
    end

    // Captured word: offsets from the origin and the read-side fields.
    logic signed [DW-1:0]      r_dx;
    logic signed [DW-1:0]      r_dy;
    logic signed [COORD_W-1:0] r_z;
    logic                      r_obst;
    logic                      r_op;
    logic [CELL_IX_W-1:0]      r_col;
    logic [CELL_IX_W-1:0]      r_row;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_dx   <= DW'(i_point_x) - DW'(r_origin_x);
            r_dy   <= DW'(i_point_y) - DW'(r_origin_y);
            r_z    <= i_point_z;
            r_obst <= i_point_obstacle;
            r_op   <= i_operation;
            r_col  <= i_cell_col;
            r_row  <= i_cell_row;
        end
    end

    // Offsets times the Q0.16 scale; the quotient by 65536 is the cell index.
    logic signed [PW-1:0] r_px;
    logic signed [PW-1:0] r_py;

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_px <= PW'(r_dx) * $signed({1'b0, r_cells_per_m});
            r_py <= PW'(r_dy) * $signed({1'b0, r_cells_per_m});
        end
    end

    // Truncation toward zero: a product just below zero still lands in
    // index 0, while a product of -65536 or less falls before the grid.
    logic          x_in;
    logic          y_in;
    logic [IW-1:0] col_ix;
    logic [IW-1:0] row_ix;
    logic [AW-1:0] ins_addr;
    logic [AW-1:0] rd_addr;
    logic          rd_in;

    always_comb begin
        x_in = (!r_px[PW-1] && (r_px[PW-2:16] < QW'(GRID_SIDE)))
            || ((&r_px[PW-1:16]) && (|r_px[15:0]));
        y_in = (!r_py[PW-1] && (r_py[PW-2:16] < QW'(GRID_SIDE)))
            || ((&r_py[PW-1:16]) && (|r_py[15:0]));
        col_ix   = r_px[PW-1] ? '0 : r_px[16 +: IW];
        row_ix   = r_py[PW-1] ? '0 : r_py[16 +: IW];
        ins_addr = AW'(col_ix) * AW'(GRID_SIDE) + AW'(row_ix);
        rd_in    = (32'(r_col) < GRID_SIDE) && (32'(r_row) < GRID_SIDE);
        rd_addr  = AW'(r_col) * AW'(GRID_SIDE) + AW'(r_row);
    end

    logic [AW-1:0] r_addr;
    logic          r_hit;

    always_ff @(posedge i_clk) begin
        if (i_cmd.addr) begin
            r_addr <= (r_op == OP_READ) ? rd_addr : ins_addr;
            r_hit  <= (r_op == OP_READ) ? rd_in : (x_in && y_in);
        end
    end

    // Clearing pass counter over the flag store.
    logic [AW-1:0] r_clr_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt <= '0;
        end else if (i_cmd.clr_wr) begin
            r_clr_cnt <= r_clr_cnt + 1'b1;
        end
    end

    // Cell stores: flags {used, marked} and heights {low, high}.
    logic [1:0]    flag_rd;
    logic [HW-1:0] hgt_rd;
    logic          flag_we;
    logic [AW-1:0] flag_waddr;
    logic [1:0]    flag_wdata;
    logic          hgt_we;
    logic [HW-1:0] hgt_wdata;

    mmhg_ram #(
        .WIDTH (2),
        .DEPTH (CELLS)
    ) u_flags (
        .i_clk   (i_clk),
        .i_we    (flag_we),
        .i_waddr (flag_waddr),
        .i_wdata (flag_wdata),
        .i_re    (i_cmd.rd),
        .i_raddr (r_addr),
        .o_rdata (flag_rd)
    );

    mmhg_ram #(
        .WIDTH (HW),
        .DEPTH (CELLS)
    ) u_heights (
        .i_clk   (i_clk),
        .i_we    (hgt_we),
        .i_waddr (r_addr),
        .i_wdata (hgt_wdata),
        .i_re    (i_cmd.rd),
        .i_raddr (r_addr),
        .o_rdata (hgt_rd)
    );

    // Cell update: min/max on insert, flags cleared on read.
    logic                      f_used;
    logic                      f_mark;
    logic signed [COORD_W-1:0] h_low;
    logic signed [COORD_W-1:0] h_high;
    logic signed [COORD_W-1:0] n_low;
    logic signed [COORD_W-1:0] n_high;
    logic signed [DW-1:0]      spread;
    logic                      spread_obst;

    always_comb begin
        f_used      = flag_rd[1];
        f_mark      = flag_rd[0];
        h_low       = $signed(hgt_rd[HW-1:COORD_W]);
        h_high      = $signed(hgt_rd[COORD_W-1:0]);
        n_low       = (!f_used || (r_z < h_low))  ? r_z : h_low;
        n_high      = (!f_used || (r_z > h_high)) ? r_z : h_high;
        spread      = DW'(h_high) - DW'(h_low);
        spread_obst = spread > $signed(DW'(r_limit));

        flag_we    = i_cmd.clr_wr || i_cmd.modify;
        flag_waddr = i_cmd.clr_wr ? r_clr_cnt : r_addr;
        if (i_cmd.clr_wr || (r_op == OP_READ)) begin
            flag_wdata = 2'b00;
        end else begin
            flag_wdata = {1'b1, f_mark | r_obst};
        end
        hgt_we    = i_cmd.modify && (r_op == OP_INSERT);
        hgt_wdata = {n_low, n_high};
    end

    // Result of a read, held until the output register is free.
    logic                      r_res_used;
    logic signed [COORD_W-1:0] r_res_top;
    logic                      r_res_obst;

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_zero) begin
            r_res_used <= 1'b0;
            r_res_top  <= '0;
            r_res_obst <= 1'b0;
        end else if (i_cmd.modify) begin
            r_res_used <= f_used;
            r_res_top  <= f_used ? h_high : '0;
            r_res_obst <= f_used && (f_mark || spread_obst);
        end
    end

    // Output register.
    logic                      r_out_valid;
    logic                      r_out_used;
    logic signed [COORD_W-1:0] r_out_top;
    logic                      r_out_obst;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.deliver) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.deliver) begin
            r_out_used <= r_res_used;
            r_out_top  <= r_res_top;
            r_out_obst <= r_res_obst;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_cell_used     = r_out_used;
    assign o_top_height    = r_out_top;
    assign o_cell_obstacle = r_out_obst;

    // Status to the controller.
    assign o_sts.op_read  = (r_op == OP_READ);
    assign o_sts.hit      = r_hit;
    assign o_sts.clr_last = (r_clr_cnt == AW'(CELLS - 1));
    assign o_sts.out_free = !r_out_valid || i_out_ready;
endmodule

// File: hw/rtl/min_max_height_grid.sv
// Min/max height grid: bins points into a square grid of cells and reports
// one cell's used flag, top height and obstacle flag on a read.
//
// The input channel i_req carries one word: an insert (point x, y, z and an
// obstacle mark) or a read (cell column and row). An insert that misses the
// grid ends after the read step, one that lands in a cell after the update
// step; it produces no result word. A read ends in the delivery step, which
// writes its result word into the output register of o_rsp; it skips the
// update when the cell lies outside the grid. The controller steps each
// word through the scale multiply, the address compute and one read-modify-
// write of the cell stores, so one word is in work at a time.
// Configuration is written through i_cfg_we / i_cfg_index / i_cfg_data.
//
// After reset the block clears the used and marked flags of every cell, one
// cell per cycle, GRID_SIDE * GRID_SIDE cells (16384 at the default), and
// accepts no word until that pass ends. When the receiver stalls, the result
// waits in the output register and the block still accepts the next word;
// a second read then waits in its delivery step until the register frees.
// Depends on mmhg_pkg, mmhg_req_if, mmhg_rsp_if, mmhg_ctrl and mmhg_dp.
module min_max_height_grid #(
    parameter int GRID_SIDE = mmhg_pkg::GRID_SIDE_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [mmhg_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [mmhg_pkg::CFG_DAT_W-1:0] i_cfg_data,
    mmhg_req_if.sink                       i_req,
    mmhg_rsp_if.source                     o_rsp
);
    import mmhg_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // Controller.
    mmhg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (i_req.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Datapath with the cell stores.
    mmhg_dp #(
        .GRID_SIDE (GRID_SIDE)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_operation      (i_req.operation),
        .i_point_x        (i_req.point_x),
        .i_point_y        (i_req.point_y),
        .i_point_z        (i_req.point_z),
        .i_point_obstacle (i_req.point_obstacle),
        .i_cell_col       (i_req.cell_col),
        .i_cell_row       (i_req.cell_row),
        .o_out_valid      (o_rsp.valid),
        .i_out_ready      (o_rsp.ready),
        .o_cell_used      (o_rsp.cell_used),
        .o_top_height     (o_rsp.top_height),
        .o_cell_obstacle  (o_rsp.cell_obstacle),
        .i_cmd            (cmd),
        .o_sts            (sts)
    );
endmodule
